>>> hw/rtl/ccrwg_pkg.sv
// shared types, constants and helpers of the chacha20 random word generator
package ccrwg_pkg;

  localparam int unsigned WORD_W      = 32;
  localparam int unsigned VALUE_W     = 31;
  localparam int unsigned NUM_KEY     = 8;
  localparam int unsigned NUM_NONCE   = 3;
  localparam int unsigned NUM_SECRET  = NUM_KEY + NUM_NONCE;
  localparam int unsigned NUM_WORDS   = 16;
  localparam int unsigned NUM_LANES   = 4;
  localparam int unsigned NUM_HALF    = 20;
  localparam int unsigned SEED_ROT    = 7;
  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned CFG_INDEX_W = 3;

  typedef logic [WORD_W-1:0]      word_t;
  typedef logic [VALUE_W-1:0]     value_t;
  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
  typedef logic [1:0]             qr_step_t;

  // configuration register indexes
  localparam cfg_index_t REG_SECRET_0_1 = 3'd0;
  localparam cfg_index_t REG_SECRET_2_3 = 3'd1;
  localparam cfg_index_t REG_SECRET_4_5 = 3'd2;
  localparam cfg_index_t REG_SECRET_6_7 = 3'd3;
  localparam cfg_index_t REG_SECRET_8_9 = 3'd4;
  localparam cfg_index_t REG_SECRET_10  = 3'd5;

  // quarter round steps: add, xor, rotate by the named amount
  localparam qr_step_t STEP_A16 = 2'd0;
  localparam qr_step_t STEP_C12 = 2'd1;
  localparam qr_step_t STEP_A8  = 2'd2;
  localparam qr_step_t STEP_C7  = 2'd3;

  // "expand 32-byte k"
  localparam word_t SIGMA_0 = 32'h6170_7865;
  localparam word_t SIGMA_1 = 32'h3320_646e;
  localparam word_t SIGMA_2 = 32'h7962_2d32;
  localparam word_t SIGMA_3 = 32'h6b20_6574;

  localparam word_t DEFAULT_SEED = 32'd1;

  // one quarter round column or diagonal of the working state
  typedef struct packed {
    word_t a;
    word_t b;
    word_t c;
    word_t d;
  } lane_t;

  // result handed from the core to the output register
  typedef struct packed {
    logic   valid;
    value_t value;
  } result_t;

  // rotate left by a constant amount
  function automatic word_t rotl(word_t v, int unsigned n);
    int unsigned m;
    m = n % WORD_W;
    if (m == 0) begin
      return v;
    end
    return (v << m) | (v >> (WORD_W - m));
  endfunction

endpackage

>>> hw/rtl/ccrwg_in_if.sv
// request channel: draw or reseed item
interface ccrwg_in_if;
  logic                 valid;
  logic                 ready;
  logic                 kind;
  ccrwg_pkg::word_t     seed;

  modport source (output valid, output kind, output seed, input ready);
  modport sink (input valid, input kind, input seed, output ready);
endinterface

>>> hw/rtl/ccrwg_out_if.sv
// result channel: one random value item per draw
interface ccrwg_out_if;
  logic                 valid;
  logic                 ready;
  ccrwg_pkg::value_t    random_value;

  modport source (output valid, output random_value, input ready);
  modport sink (input valid, input random_value, output ready);
endinterface

>>> hw/rtl/ccrwg_qr_unit.sv
// shared quarter round step unit: one add, xor and rotate per lane
module ccrwg_qr_unit (
  input  ccrwg_pkg::qr_step_t step,
  input  ccrwg_pkg::lane_t    lanes_in  [ccrwg_pkg::NUM_LANES],
  output ccrwg_pkg::lane_t    lanes_out [ccrwg_pkg::NUM_LANES]
);

  for (genvar j = 0; j < ccrwg_pkg::NUM_LANES; j++) begin : g_lane
    // one of the four quarter round steps on this lane
    always_comb begin
      ccrwg_pkg::lane_t l;
      l = lanes_in[j];
      case (step)
        ccrwg_pkg::STEP_A16: begin
          l.a = l.a + l.b;
          l.d = ccrwg_pkg::rotl(l.d ^ l.a, 16);
        end
        ccrwg_pkg::STEP_C12: begin
          l.c = l.c + l.d;
          l.b = ccrwg_pkg::rotl(l.b ^ l.c, 12);
        end
        ccrwg_pkg::STEP_A8: begin
          l.a = l.a + l.b;
          l.d = ccrwg_pkg::rotl(l.d ^ l.a, 8);
        end
        default: begin
          l.c = l.c + l.d;
          l.b = ccrwg_pkg::rotl(l.b ^ l.c, 7);
        end
      endcase
      lanes_out[j] = l;
    end
  end

endmodule

>>> hw/rtl/ccrwg_core.sv
// block sequencer: key schedule, round loop over the shared unit, word output
module ccrwg_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_kind,
  input  ccrwg_pkg::word_t     in_seed,
  output logic                 in_ready,
  input  ccrwg_pkg::word_t     secret [ccrwg_pkg::NUM_SECRET],
  input  logic                 slot_free,
  output ccrwg_pkg::result_t   res
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ROUND = 2'd1;
  localparam logic [1:0] ST_FINAL = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  localparam int unsigned HALF_W = $clog2(ccrwg_pkg::NUM_HALF);
  localparam logic [HALF_W-1:0] LAST_HALF = HALF_W'(ccrwg_pkg::NUM_HALF - 1);
  localparam int unsigned IDX_W = $clog2(ccrwg_pkg::NUM_WORDS);

  logic [1:0]               state;
  logic                     seeded;
  logic [IDX_W:0]           word_idx;
  ccrwg_pkg::word_t         counter;
  ccrwg_pkg::word_t         kn [ccrwg_pkg::NUM_SECRET];
  ccrwg_pkg::word_t         x  [ccrwg_pkg::NUM_WORDS];
  logic [HALF_W-1:0]        half;
  ccrwg_pkg::qr_step_t      step;

  logic                     accept;
  logic                     do_seed;
  logic                     diag;
  ccrwg_pkg::word_t         seed_src;
  ccrwg_pkg::word_t         kn_fresh [ccrwg_pkg::NUM_SECRET];
  ccrwg_pkg::word_t         kn_use   [ccrwg_pkg::NUM_SECRET];
  ccrwg_pkg::word_t         ctr_use;
  ccrwg_pkg::word_t         init     [ccrwg_pkg::NUM_WORDS];
  ccrwg_pkg::word_t         x_round  [ccrwg_pkg::NUM_WORDS];
  ccrwg_pkg::lane_t         lanes_in  [ccrwg_pkg::NUM_LANES];
  ccrwg_pkg::lane_t         lanes_out [ccrwg_pkg::NUM_LANES];

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_ready && in_valid;
  // an explicit reseed, or the implicit one before the first draw
  assign do_seed  = accept && (in_kind || !seeded);
  assign seed_src = in_kind ? in_seed : ccrwg_pkg::DEFAULT_SEED;
  assign diag     = half[0];

  // key schedule: secret words mixed with rotated copies of the seed
  for (genvar i = 0; i < ccrwg_pkg::NUM_KEY; i++) begin : g_key
    localparam int unsigned ROT = (ccrwg_pkg::SEED_ROT * i) % ccrwg_pkg::WORD_W;
    assign kn_fresh[i] = secret[i] ^ ccrwg_pkg::rotl(seed_src, ROT);
  end
  for (genvar i = 0; i < ccrwg_pkg::NUM_NONCE; i++) begin : g_nonce
    localparam int unsigned ROT =
      (ccrwg_pkg::WORD_W - (ccrwg_pkg::SEED_ROT * i) % ccrwg_pkg::WORD_W) % ccrwg_pkg::WORD_W;
    assign kn_fresh[ccrwg_pkg::NUM_KEY + i] =
      secret[ccrwg_pkg::NUM_KEY + i] ^ ccrwg_pkg::rotl(seed_src, ROT);
  end

  // block input words, from the new key when a seed lands this cycle
  for (genvar i = 0; i < ccrwg_pkg::NUM_SECRET; i++) begin : g_use
    assign kn_use[i] = do_seed ? kn_fresh[i] : kn[i];
  end
  assign ctr_use = do_seed ? '0 : counter;

  assign init[0] = ccrwg_pkg::SIGMA_0;
  assign init[1] = ccrwg_pkg::SIGMA_1;
  assign init[2] = ccrwg_pkg::SIGMA_2;
  assign init[3] = ccrwg_pkg::SIGMA_3;
  for (genvar i = 0; i < ccrwg_pkg::NUM_KEY; i++) begin : g_init_key
    assign init[4 + i] = kn_use[i];
  end
  assign init[12] = ctr_use;
  for (genvar i = 0; i < ccrwg_pkg::NUM_NONCE; i++) begin : g_init_nonce
    assign init[13 + i] = kn_use[ccrwg_pkg::NUM_KEY + i];
  end

  // gather columns or diagonals into the lanes
  for (genvar j = 0; j < ccrwg_pkg::NUM_LANES; j++) begin : g_gather
    localparam int unsigned DB = 4 + (j + 1) % 4;
    localparam int unsigned DC = 8 + (j + 2) % 4;
    localparam int unsigned DD = 12 + (j + 3) % 4;
    assign lanes_in[j] = '{
      a: x[j],
      b: diag ? x[DB] : x[4 + j],
      c: diag ? x[DC] : x[8 + j],
      d: diag ? x[DD] : x[12 + j]
    };
  end

  ccrwg_qr_unit u_qr (
    .step      (step),
    .lanes_in  (lanes_in),
    .lanes_out (lanes_out)
  );

  // scatter lane results back to their words
  for (genvar k = 0; k < 4; k++) begin : g_scatter
    localparam int unsigned L1 = (k + 3) % 4;
    localparam int unsigned L2 = (k + 2) % 4;
    localparam int unsigned L3 = (k + 1) % 4;
    assign x_round[k]      = lanes_out[k].a;
    assign x_round[4 + k]  = diag ? lanes_out[L1].b : lanes_out[k].b;
    assign x_round[8 + k]  = diag ? lanes_out[L2].c : lanes_out[k].c;
    assign x_round[12 + k] = diag ? lanes_out[L3].d : lanes_out[k].d;
  end

  // working state and keystream words, loaded only for a draw that needs a new block
  always_ff @(posedge clk) begin
    if (accept && !in_kind && (do_seed || word_idx[IDX_W])) begin
      x <= init;
    end else if (state == ST_ROUND) begin
      x <= x_round;
    end else if (state == ST_FINAL) begin
      for (int i = 0; i < ccrwg_pkg::NUM_WORDS; i++) begin
        x[i] <= x[i] + init[i];
      end
    end
  end

  // sequencer and generator state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      seeded   <= 1'b0;
      word_idx <= (IDX_W + 1)'(ccrwg_pkg::NUM_WORDS);
      counter  <= '0;
      half     <= '0;
      step     <= ccrwg_pkg::STEP_A16;
      for (int i = 0; i < ccrwg_pkg::NUM_SECRET; i++) begin
        kn[i] <= '0;
      end
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (do_seed) begin
            kn       <= kn_fresh;
            counter  <= '0;
            word_idx <= (IDX_W + 1)'(ccrwg_pkg::NUM_WORDS);
            seeded   <= 1'b1;
          end
          if (accept && !in_kind) begin
            half <= '0;
            step <= ccrwg_pkg::STEP_A16;
            if (do_seed || word_idx[IDX_W]) begin
              state <= ST_ROUND;
            end else begin
              state <= ST_EMIT;
            end
          end
        end
        ST_ROUND: begin
          step <= ccrwg_pkg::qr_step_t'(step + 2'd1);
          if (step == ccrwg_pkg::STEP_C7) begin
            half <= half + 1'b1;
            if (half == LAST_HALF) begin
              state <= ST_FINAL;
            end
          end
        end
        ST_FINAL: begin
          counter  <= counter + 1'b1;
          word_idx <= '0;
          state    <= ST_EMIT;
        end
        ST_EMIT: begin
          if (slot_free) begin
            word_idx <= word_idx + 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // next keystream word with the top bit dropped
  assign res.valid = (state == ST_EMIT) && slot_free;
  assign res.value = x[word_idx[IDX_W-1:0]][ccrwg_pkg::VALUE_W-1:0];

endmodule

>>> hw/rtl/chacha20_random_word_generator_unit.sv
// top level: secret registers, generator core and result register
// a reseed item gives no result and leaves the core ready for the next item
// a draw from a held block goes from idle to the emit state, then into the result register
// a draw that needs a new block runs 80 round steps of the shared
// quarter round unit (4 lanes, one add-xor-rotate step each cycle), then the final add and the output
// rst clears secrets, key, counter and seed flag
module chacha20_random_word_generator_unit (
  input  logic                      clk,
  input  logic                      rst,
  ccrwg_in_if.sink                  req,
  ccrwg_out_if.source               rsp,
  input  logic                      cfg_we,
  input  ccrwg_pkg::cfg_index_t     cfg_index,
  input  logic [ccrwg_pkg::CFG_DATA_W-1:0] cfg_data
);

  ccrwg_pkg::word_t    secret [ccrwg_pkg::NUM_SECRET];
  ccrwg_pkg::result_t  res;
  logic                core_ready;
  logic                slot_free;
  logic                out_valid;
  ccrwg_pkg::value_t   out_value;

  // secret configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ccrwg_pkg::NUM_SECRET; i++) begin
        secret[i] <= '0;
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        ccrwg_pkg::REG_SECRET_0_1: begin
          secret[0] <= cfg_data[31:0];
          secret[1] <= cfg_data[63:32];
        end
        ccrwg_pkg::REG_SECRET_2_3: begin
          secret[2] <= cfg_data[31:0];
          secret[3] <= cfg_data[63:32];
        end
        ccrwg_pkg::REG_SECRET_4_5: begin
          secret[4] <= cfg_data[31:0];
          secret[5] <= cfg_data[63:32];
        end
        ccrwg_pkg::REG_SECRET_6_7: begin
          secret[6] <= cfg_data[31:0];
          secret[7] <= cfg_data[63:32];
        end
        ccrwg_pkg::REG_SECRET_8_9: begin
          secret[8] <= cfg_data[31:0];
          secret[9] <= cfg_data[63:32];
        end
        ccrwg_pkg::REG_SECRET_10: begin
          secret[10] <= cfg_data[31:0];
        end
        default: begin
        end
      endcase
    end
  end

  ccrwg_core u_core (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_kind   (req.kind),
    .in_seed   (req.seed),
    .in_ready  (core_ready),
    .secret    (secret),
    .slot_free (slot_free),
    .res       (res)
  );

  assign req.ready = core_ready;

  // result register between core and consumer
  assign slot_free = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.valid) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_value <= res.value;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.random_value = out_value;

  // core never offers a result while taking a new item
  a_result_not_idle: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> !core_ready)
    else $error("result offered while core ready");

  // a reseed item leaves the core ready on the next cycle
  a_reseed_one_cycle: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready && req.kind |=> req.ready)
    else $error("reseed did not finish in one cycle");

  // a draw item keeps the core busy on the next cycle
  a_draw_busy: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready && !req.kind |=> !req.ready)
    else $error("core ready right after a draw");

  // a result is only loaded when the output slot is free
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (!out_valid || rsp.ready))
    else $error("result register overwritten");

endmodule

>>> dv/tb_top.sv
// testbench for the chacha20 random word generator: draws and reseeds checked against a local keystream predictor
module tb_top;
  import ccrwg_pkg::*;

  localparam logic KIND_DRAW   = 1'b0;
  localparam logic KIND_RESEED = 1'b1;

  localparam int unsigned BLOCK_LATENCY = 90;
  localparam int unsigned STALL_LIMIT   = 3000;
  localparam int unsigned RANDOM_ITEMS  = 260;

  typedef enum {FILL_ZERO, FILL_ONES, FILL_RANDOM} secret_fill_t;

  logic clk;
  logic rst;
  logic cfg_we;
  cfg_index_t cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  ccrwg_in_if  req ();
  ccrwg_out_if rsp ();

  chacha20_random_word_generator_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // predictor state
  word_t secret_words [NUM_SECRET];
  word_t key_nonce [NUM_SECRET];
  word_t block_count;
  word_t keystream [NUM_WORDS];
  word_t mix [NUM_WORDS];
  int unsigned word_pos;
  bit seeded;

  value_t expected_values [$];
  int unsigned error_count;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned stall_cycles;

  function automatic word_t rot_word(word_t v, int unsigned n);
    int unsigned m;
    m = n % WORD_W;
    if (m == 0) begin
      return v;
    end
    return (v << m) | (v >> (WORD_W - m));
  endfunction

  function automatic void quarter_mix(int unsigned a, int unsigned b,
                                      int unsigned c, int unsigned d);
    mix[a] = mix[a] + mix[b]; mix[d] = rot_word(mix[d] ^ mix[a], 16);
    mix[c] = mix[c] + mix[d]; mix[b] = rot_word(mix[b] ^ mix[c], 12);
    mix[a] = mix[a] + mix[b]; mix[d] = rot_word(mix[d] ^ mix[a], 8);
    mix[c] = mix[c] + mix[d]; mix[b] = rot_word(mix[b] ^ mix[c], 7);
  endfunction

  // one 20-round block from key, counter and nonce
  function automatic void refill_block();
    word_t start [NUM_WORDS];
    start[0] = SIGMA_0;
    start[1] = SIGMA_1;
    start[2] = SIGMA_2;
    start[3] = SIGMA_3;
    for (int i = 0; i < 8; i++) start[4 + i] = key_nonce[i];
    start[12] = block_count;
    for (int i = 0; i < 3; i++) start[13 + i] = key_nonce[8 + i];
    mix = start;
    for (int r = 0; r < 10; r++) begin
      quarter_mix(0, 4, 8, 12);  quarter_mix(1, 5, 9, 13);
      quarter_mix(2, 6, 10, 14); quarter_mix(3, 7, 11, 15);
      quarter_mix(0, 5, 10, 15); quarter_mix(1, 6, 11, 12);
      quarter_mix(2, 7, 8, 13);  quarter_mix(3, 4, 9, 14);
    end
    for (int i = 0; i < NUM_WORDS; i++) keystream[i] = mix[i] + start[i];
  endfunction

  // key and nonce derived from seed and secret
  function automatic void derive_key(word_t seed);
    for (int unsigned i = 0; i < 8; i++) begin
      key_nonce[i] = secret_words[i] ^ rot_word(seed, 7 * i);
    end
    for (int unsigned i = 0; i < 3; i++) begin
      key_nonce[8 + i] = secret_words[8 + i] ^ rot_word(seed, 32 - 7 * i);
    end
    block_count = '0;
    word_pos = NUM_WORDS;
    seeded = 1'b1;
  endfunction

  // expected outcome of one accepted item
  function automatic void predict_item(logic kind, word_t seed);
    if (kind == KIND_RESEED) begin
      derive_key(seed);
      return;
    end
    if (!seeded) begin
      derive_key(DEFAULT_SEED);
    end
    if (word_pos >= NUM_WORDS) begin
      refill_block();
      block_count = block_count + 1;
      word_pos = 0;
    end
    expected_values.push_back(keystream[word_pos][VALUE_W-1:0]);
    word_pos++;
  endfunction

  // drive one item and wait for its handshake
  task automatic send_item(logic kind, word_t seed);
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid = 1'b0;
      @(negedge clk);
    end
    req.valid = 1'b1;
    req.kind  = kind;
    req.seed  = seed;
    do @(posedge clk); while (!req.ready);
    predict_item(kind, seed);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    req.valid = 1'b0;
    while (expected_values.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // block idle: all results in, then room for a block still in flight
  task automatic settle_idle();
    wait_drained();
    repeat (BLOCK_LATENCY) @(negedge clk);
  endtask

  task automatic write_reg(cfg_index_t index, logic [CFG_DATA_W-1:0] data);
    cfg_we    = 1'b1;
    cfg_index = index;
    cfg_data  = data;
    @(negedge clk);
    cfg_we = 1'b0;
    if (index == REG_SECRET_10) begin
      secret_words[10] = data[31:0];
    end else begin
      secret_words[2 * index]     = data[31:0];
      secret_words[2 * index + 1] = data[63:32];
    end
  endtask

  task automatic load_secrets(secret_fill_t fill);
    logic [CFG_DATA_W-1:0] data;
    for (int i = 0; i <= REG_SECRET_10; i++) begin
      case (fill)
        FILL_ZERO: data = '0;
        FILL_ONES: data = '1;
        default:   data = {$urandom, $urandom};
      endcase
      if (cfg_index_t'(i) == REG_SECRET_10) begin
        data[63:32] = '0;
      end
      write_reg(cfg_index_t'(i), data);
    end
  endtask

  // first draw seeds itself with the default seed and the current secret
  task automatic test_unseeded_draw();
    load_secrets(FILL_RANDOM);
    send_item(KIND_DRAW, $urandom);
    req.valid = 1'b0;
  endtask

  // explicit reseeds, a block boundary and back-to-back reseeds
  task automatic test_reseed_refill();
    send_item(KIND_RESEED, 32'h0000_0000);
    repeat (17) send_item(KIND_DRAW, $urandom);
    send_item(KIND_RESEED, 32'hFFFF_FFFF);
    send_item(KIND_DRAW, 32'hFFFF_FFFF);
    send_item(KIND_RESEED, 32'h8000_0000);
    send_item(KIND_RESEED, 32'h1234_5678);
    send_item(KIND_DRAW, 32'h0000_0000);
    req.valid = 1'b0;
  endtask

  // random mix of draws and reseeds; new secret takes effect at the next reseed only
  task automatic test_random(int unsigned idle_pct, int unsigned stall_pct,
                             secret_fill_t fill, int unsigned count);
    logic kind;
    word_t seed;
    settle_idle();
    load_secrets(fill);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int unsigned n = 0; n < count; n++) begin
      kind = ($urandom_range(19) == 0) ? KIND_RESEED : KIND_DRAW;
      case ($urandom_range(9))
        0:       seed = '0;
        1:       seed = '1;
        2:       seed = DEFAULT_SEED;
        default: seed = $urandom;
      endcase
      if (n == count / 2) begin
        wait_drained();
      end
      send_item(kind, seed);
    end
    req.valid = 1'b0;
  endtask

  // receiver readiness
  initial begin
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      rsp.ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // result check against the oldest expected value
  always @(posedge clk) begin
    value_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      if (expected_values.size() == 0) begin
        $display("%0t: unexpected random_value, expected none, actual %h",
                 $time, rsp.random_value);
        error_count++;
      end else begin
        want = expected_values.pop_front();
        if (rsp.random_value !== want) begin
          $display("%0t: random_value mismatch, expected %h, actual %h",
                   $time, want, rsp.random_value);
          error_count++;
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  initial begin
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
    end
    $display("tb_top failed");
    $finish;
  end

  // test sequence
  initial begin
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = REG_SECRET_0_1;
    cfg_data  = '0;
    req.valid = 1'b0;
    req.kind  = KIND_DRAW;
    req.seed  = '0;
    error_count    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    secret_words   = '{default: '0};
    key_nonce      = '{default: '0};
    keystream      = '{default: '0};
    block_count    = '0;
    word_pos       = NUM_WORDS;
    seeded         = 1'b0;
    repeat (12) @(negedge clk);
    rst = 1'b0;

    test_unseeded_draw();
    test_reseed_refill();
    test_random(0, 0, FILL_ONES, RANDOM_ITEMS);
    test_random(55, 0, FILL_ZERO, RANDOM_ITEMS);
    test_random(0, 55, FILL_RANDOM, RANDOM_ITEMS);
    test_random(31, 31, FILL_RANDOM, RANDOM_ITEMS);

    wait_drained();
    repeat (BLOCK_LATENCY) @(posedge clk);
    if (error_count == 0 && expected_values.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
